### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers of the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_STR     = 3'd1,
		MODE_ESC     = 3'd2,
		MODE_HEX_HI  = 3'd3,
		MODE_WAIT_BS = 3'd4,
		MODE_WAIT_U  = 3'd5,
		MODE_HEX_LO  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
	localparam logic [3:0] ERR_CONTROL   = 4'd2;
	localparam logic [3:0] ERR_ESCAPE    = 4'd3;
	localparam logic [3:0] ERR_HEX       = 4'd4;
	localparam logic [3:0] ERR_PAIR      = 4'd5;
	localparam logic [3:0] ERR_UNPAIRED  = 4'd6;
	localparam logic [3:0] ERR_EOT_STR   = 4'd7;
	localparam logic [3:0] ERR_EOT_ESC   = 4'd8;
	localparam logic [3:0] ERR_EOT_HEX   = 4'd9;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// one parsed byte turned into up to four result words
	typedef struct packed {
		logic [2:0]       cnt;
		logic [3:0][7:0]  bytes;
		kind_t            kind;
		logic [3:0]       err;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       cnt;
		logic [3:0][7:0]  bytes;
	} utf8_t;

	// {ok, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= 21'h7F) begin
			r.cnt      = 3'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			r.cnt      = 3'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.cnt      = 3'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.cnt      = 3'd4;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

### rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one JSON text byte or an end-of-text mark per word.
// ----------------------------------------------------------------------------
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, text_byte, end_of_text, input ready);
	modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

### rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded byte, string close or error per word.
// ----------------------------------------------------------------------------
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [3:0] error_code;
	logic       last_of_run;

	modport source(output valid, out_byte, kind, error_code, last_of_run, input ready);
	modport sink(input valid, out_byte, kind, error_code, last_of_run, output ready);
endinterface

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser: scans one text byte per cycle while the queue has room and turns it into at most one result command.
// ----------------------------------------------------------------------------
module jsu_front
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	jsu_in_if.sink     text,
	input  logic       cmd_ready,
	output logic       cmd_push,
	output cmd_t       cmd
);

	mode_t       mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [9:0]  held_q, held_d;

	logic        fire;
	logic        fail;
	logic [3:0]  fail_code;
	logic [4:0]  nib;
	logic [15:0] acc_shift;
	logic [20:0] cp_sel;
	utf8_t       enc;
	logic [7:0]  c;

	assign c          = text.text_byte;
	assign fire       = text.valid && cmd_ready;
	assign text.ready = cmd_ready;
	assign cmd_push   = fire && (cmd.cnt != 3'd0);

	assign nib       = hex_nibble(c);
	assign acc_shift = {acc_q[11:0], nib[3:0]};
	assign cp_sel    = (mode_q == MODE_HEX_LO)
		? 21'h10000 + {1'b0, held_q, acc_shift[9:0]}
		: {5'd0, acc_shift};
	assign enc       = utf8_encode(cp_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			dcnt_q <= '0;
			held_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			dcnt_q <= dcnt_d;
			held_q <= held_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		dcnt_d    = dcnt_q;
		held_d    = held_q;
		cmd       = '0;
		cmd.kind  = KIND_DATA;
		fail      = 1'b0;
		fail_code = ERR_NONE;

		if (text.end_of_text) begin
			unique case (mode_q)
				MODE_IDLE: fail = 1'b0;
				MODE_STR: begin
					fail      = 1'b1;
					fail_code = ERR_EOT_STR;
				end
				MODE_ESC: begin
					fail      = 1'b1;
					fail_code = ERR_EOT_ESC;
				end
				default: begin
					fail      = 1'b1;
					fail_code = ERR_EOT_HEX;
				end
			endcase
			mode_d = MODE_IDLE;
			acc_d  = '0;
			dcnt_d = '0;
			held_d = '0;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (c == CH_QUOTE) begin
						mode_d = MODE_STR;
					end else begin
						fail      = 1'b1;
						fail_code = ERR_NO_QUOTE;
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						cmd.cnt  = 3'd1;
						cmd.kind = KIND_CLOSE;
						mode_d   = MODE_IDLE;
						acc_d    = '0;
						dcnt_d   = '0;
						held_d   = '0;
					end else if (c < CH_SPACE) begin
						fail      = 1'b1;
						fail_code = ERR_CONTROL;
					end else if (c == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						cmd.cnt      = 3'd1;
						cmd.bytes[0] = c;
					end
				end
				MODE_ESC: begin
					mode_d       = MODE_STR;
					cmd.cnt      = 3'd1;
					unique case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: cmd.bytes[0] = c;
						CH_LOW_B: cmd.bytes[0] = 8'h08;
						CH_LOW_F: cmd.bytes[0] = 8'h0C;
						CH_LOW_N: cmd.bytes[0] = 8'h0A;
						CH_LOW_R: cmd.bytes[0] = 8'h0D;
						CH_LOW_T: cmd.bytes[0] = 8'h09;
						CH_LOW_U: begin
							cmd.cnt = 3'd0;
							mode_d  = MODE_HEX_HI;
							acc_d   = '0;
							dcnt_d  = '0;
						end
						default: begin
							cmd.cnt   = 3'd0;
							fail      = 1'b1;
							fail_code = ERR_ESCAPE;
						end
					endcase
				end
				MODE_HEX_HI, MODE_HEX_LO: begin
					if (!nib[4]) begin
						fail      = 1'b1;
						fail_code = ERR_HEX;
					end else if (dcnt_q != 2'd3) begin
						acc_d  = acc_shift;
						dcnt_d = dcnt_q + 2'd1;
					end else begin
						acc_d  = '0;
						dcnt_d = '0;
						if (mode_q == MODE_HEX_HI) begin
							if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
								held_d = acc_shift[9:0];
								mode_d = MODE_WAIT_BS;
							end else if (acc_shift >= 16'hD800 && acc_shift <= 16'hDFFF) begin
								fail      = 1'b1;
								fail_code = ERR_UNPAIRED;
							end else begin
								cmd.cnt   = enc.cnt;
								cmd.bytes = enc.bytes;
								mode_d    = MODE_STR;
							end
						end else begin
							if (acc_shift >= 16'hDC00 && acc_shift <= 16'hDFFF) begin
								cmd.cnt   = enc.cnt;
								cmd.bytes = enc.bytes;
								held_d    = '0;
								mode_d    = MODE_STR;
							end else begin
								fail      = 1'b1;
								fail_code = ERR_PAIR;
							end
						end
					end
				end
				MODE_WAIT_BS: begin
					if (c == CH_BSLASH) begin
						mode_d = MODE_WAIT_U;
					end else begin
						fail      = 1'b1;
						fail_code = ERR_UNPAIRED;
					end
				end
				MODE_WAIT_U: begin
					if (c == CH_LOW_U) begin
						mode_d = MODE_HEX_LO;
						acc_d  = '0;
						dcnt_d = '0;
					end else begin
						fail      = 1'b1;
						fail_code = ERR_UNPAIRED;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					acc_d  = '0;
					dcnt_d = '0;
					held_d = '0;
				end
			endcase
		end

		if (fail) begin
			cmd       = '0;
			cmd.cnt   = 3'd1;
			cmd.kind  = KIND_ERROR;
			cmd.err   = fail_code;
			mode_d    = MODE_IDLE;
			acc_d     = '0;
			dcnt_d    = '0;
			held_d    = '0;
		end
	end

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short command queue between parser and serializer.
// ----------------------------------------------------------------------------
module jsu_queue
	import jsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: sends each queued command out as result words, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module jsu_back
	import jsu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  cmd_t     head,
	output logic     pop,
	jsu_out_if.source result
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic [3:0] err_q;
	logic       last_q;
	logic [1:0] idx_q;

	logic       load;
	logic       take;
	logic       is_last;

	assign load    = !valid_q || result.ready;
	assign take    = load && head_valid;
	assign is_last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop     = take && is_last;

	assign result.valid       = valid_q;
	assign result.out_byte    = byte_q;
	assign result.kind        = kind_q;
	assign result.error_code  = err_q;
	assign result.last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (take) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= head.bytes[idx_q];
			kind_q <= head.kind;
			err_q  <= head.err;
			last_q <= is_last;
		end
	end

endmodule

### rtl/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the queue has room and gives decoded
// string bytes, a close mark per string and error words, one word per cycle
// while the output is ready. The parser turns each byte into zero to four
// result words; a four-entry command queue feeds a serializer that sends them
// out through an output register, so a \u escape that expands to n UTF-8
// bytes occupies the output for n words while the input keeps flowing until
// the queue fills. A result word passes the queue and the output register.
// After an error the unit is idle and expects an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    text,
	jsu_out_if.source result
);

	logic cmd_push;
	cmd_t cmd;
	logic q_full;
	logic q_pop;
	logic head_valid;
	cmd_t head;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.cmd_ready (!q_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	jsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.result     (result)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string unescape unit.
// ----------------------------------------------------------------------------
// Streams JSON text into the unit with random gaps while the result side
// stalls at random. Every accepted input word is run through a local decoder
// that tracks the scan state and builds the decoded bytes, close marks and
// error words that word must produce; result words are checked in order.
// Most of the text is well-formed strings with escapes and surrogate pairs,
// the rest is idle noise, malformed escapes and truncated text.
// ----------------------------------------------------------------------------
module tb;
	import jsu_pkg::*;

	localparam int DIRECTED_ITEMS = 25;
	localparam int RUN_ITEMS      = DIRECTED_ITEMS + 245;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic [3:0] code;
		logic       last;
	} decoded_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       eot;
		logic       hold;
	} text_word_t;

	logic clk;
	logic arst_n;

	jsu_in_if  text_ch();
	jsu_out_if res_ch();

	json_string_unescape_utf8_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (res_ch)
	);

	text_word_t text_q[$];
	decoded_t   decoded_q[$];
	decoded_t   run_q[$];

	mode_t       p_mode;
	logic [15:0] p_acc;
	logic [1:0]  p_digits;
	logic [9:0]  p_high;

	int   words_made;
	int   mismatches;
	int   cycles;
	int   gap_left;
	int   stall_left;
	int   calm_left[2];
	logic in_fire;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- decoder

	function automatic void clear_state();
		p_mode   = MODE_IDLE;
		p_acc    = '0;
		p_digits = '0;
		p_high   = '0;
	endfunction

	function automatic void put_result(input logic [7:0] d, input kind_t k,
			input logic [3:0] e);
		decoded_t r;
		r.data = d;
		r.kind = k;
		r.code = e;
		r.last = 1'b0;
		run_q.insert(run_q.size(), r);
	endfunction

	function automatic void fail(input logic [3:0] e);
		put_result(8'h00, KIND_ERROR, e);
		clear_state();
	endfunction

	function automatic int digit_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void push_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_result(cp[7:0], KIND_DATA, ERR_NONE);
		end else if (cp < 21'h800) begin
			put_result(8'hC0 | 8'(cp >> 6), KIND_DATA, ERR_NONE);
			put_result(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
		end else if (cp < 21'h10000) begin
			put_result(8'hE0 | 8'(cp >> 12), KIND_DATA, ERR_NONE);
			put_result(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_NONE);
			put_result(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
		end else begin
			put_result(8'hF0 | 8'((cp >> 18) & 21'h7), KIND_DATA, ERR_NONE);
			put_result(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA, ERR_NONE);
			put_result(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_NONE);
			put_result(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
		end
	endfunction

	function automatic void unescape_step(input logic [7:0] c, input logic eot);
		int          v;
		logic [15:0] cp;
		run_q.delete();
		if (eot) begin
			case (p_mode)
				MODE_IDLE: ;
				MODE_STR:  fail(ERR_EOT_STR);
				MODE_ESC:  fail(ERR_EOT_ESC);
				default:   fail(ERR_EOT_HEX);
			endcase
			clear_state();
		end else begin
			case (p_mode)
				MODE_IDLE: begin
					if (c == CH_QUOTE) p_mode = MODE_STR;
					else fail(ERR_NO_QUOTE);
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						put_result(8'h00, KIND_CLOSE, ERR_NONE);
						clear_state();
					end else if (c < CH_SPACE) begin
						fail(ERR_CONTROL);
					end else if (c == CH_BSLASH) begin
						p_mode = MODE_ESC;
					end else begin
						put_result(c, KIND_DATA, ERR_NONE);
					end
				end
				MODE_ESC: begin
					p_mode = MODE_STR;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: put_result(c, KIND_DATA, ERR_NONE);
						CH_LOW_B: put_result(8'h08, KIND_DATA, ERR_NONE);
						CH_LOW_F: put_result(8'h0C, KIND_DATA, ERR_NONE);
						CH_LOW_N: put_result(8'h0A, KIND_DATA, ERR_NONE);
						CH_LOW_R: put_result(8'h0D, KIND_DATA, ERR_NONE);
						CH_LOW_T: put_result(8'h09, KIND_DATA, ERR_NONE);
						CH_LOW_U: begin
							p_mode   = MODE_HEX_HI;
							p_acc    = '0;
							p_digits = '0;
						end
						default: fail(ERR_ESCAPE);
					endcase
				end
				MODE_HEX_HI, MODE_HEX_LO: begin
					v = digit_of(c);
					if (v < 0) begin
						fail(ERR_HEX);
					end else begin
						p_acc = {p_acc[11:0], 4'(v)};
						if (p_digits != 2'd3) begin
							p_digits = p_digits + 2'd1;
						end else begin
							p_digits = '0;
							cp       = p_acc;
							p_acc    = '0;
							if (p_mode == MODE_HEX_HI) begin
								if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
									p_high = cp[9:0];
									p_mode = MODE_WAIT_BS;
								end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
									fail(ERR_UNPAIRED);
								end else begin
									push_code_point({5'd0, cp});
									p_mode = MODE_STR;
								end
							end else begin
								if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
									push_code_point(21'h10000 + 21'({p_high, cp[9:0]}));
									p_high = '0;
									p_mode = MODE_STR;
								end else begin
									fail(ERR_PAIR);
								end
							end
						end
					end
				end
				MODE_WAIT_BS: begin
					if (c == CH_BSLASH) p_mode = MODE_WAIT_U;
					else fail(ERR_UNPAIRED);
				end
				MODE_WAIT_U: begin
					if (c == CH_LOW_U) begin
						p_mode   = MODE_HEX_LO;
						p_acc    = '0;
						p_digits = '0;
					end else begin
						fail(ERR_UNPAIRED);
					end
				end
				default: clear_state();
			endcase
		end
		if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
		foreach (run_q[i]) decoded_q.insert(decoded_q.size(), run_q[i]);
	endfunction

	// ---------------------------------------------------------------- text generation

	function automatic int pick_gap(input int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left[side] = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		text_word_t w;
		w.chr  = b;
		w.eot  = 1'b0;
		w.hold = 1'b0;
		text_q.insert(text_q.size(), w);
		words_made++;
	endtask

	task automatic push_eot();
		text_word_t w;
		w.chr  = 8'($urandom_range(0, 255));
		w.eot  = 1'b1;
		w.hold = 1'b0;
		text_q.insert(text_q.size(), w);
		words_made++;
	endtask

	task automatic push_hold();
		text_word_t w;
		w.chr  = 8'h00;
		w.eot  = 1'b0;
		w.hold = 1'b1;
		text_q.insert(text_q.size(), w);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	task automatic push_hex_digits(input logic [15:0] v, input int count);
		for (int i = 3; i > 3 - count; i--) push_byte(hex_char(v[i*4 +: 4]));
	endtask

	task automatic push_u(input logic [15:0] v);
		push_byte(CH_BSLASH);
		push_byte(CH_LOW_U);
		push_hex_digits(v, 4);
	endtask

	function automatic logic [7:0] escape_letter(input int i);
		case (i)
			0:       return CH_QUOTE;
			1:       return CH_BSLASH;
			2:       return CH_SLASH;
			3:       return CH_LOW_B;
			4:       return CH_LOW_F;
			5:       return CH_LOW_N;
			6:       return CH_LOW_R;
			default: return CH_LOW_T;
		endcase
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] b);
		for (int i = 0; i < 8; i++) if (b == escape_letter(i)) return 1'b1;
		return b == CH_LOW_U;
	endfunction

	function automatic logic [15:0] bmp_point();
		int r;
		logic [15:0] v;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				case ($urandom_range(0, 7))
					0:       v = 16'h0000;
					1:       v = 16'h007F;
					2:       v = 16'h0080;
					3:       v = 16'h07FF;
					4:       v = 16'h0800;
					5:       v = 16'hD7FF;
					6:       v = 16'hE000;
					default: v = 16'hFFFF;
				endcase
			end
			1, 2, 3: v = 16'($urandom_range('h0, 'h7F));
			4, 5, 6: v = 16'($urandom_range('h80, 'h7FF));
			default: begin
				v = 16'($urandom_range('h800, 'hFFFF));
				if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
			end
		endcase
		return v;
	endfunction

	function automatic logic [15:0] high_half();
		return 16'hD800 + 16'($urandom_range(0, 1023));
	endfunction

	function automatic logic [15:0] low_half();
		return 16'hDC00 + 16'($urandom_range(0, 1023));
	endfunction

	task automatic push_fault();
		logic [7:0]  b;
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: push_byte(8'($urandom_range(0, 'h1F)));
			1: begin
				do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
				push_byte(CH_BSLASH);
				push_byte(b);
			end
			2: begin
				do b = 8'($urandom_range(0, 255)); while (digit_of(b) >= 0);
				if ($urandom_range(0, 1)) push_u(high_half());
				push_byte(CH_BSLASH);
				push_byte(CH_LOW_U);
				push_hex_digits(16'($urandom_range(0, 'hFFFF)), $urandom_range(0, 3));
				push_byte(b);
			end
			3: push_u(low_half());
			4: begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
				push_u(high_half());
				push_byte(b);
			end
			5: begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_LOW_U);
				push_u(high_half());
				push_byte(CH_BSLASH);
				push_byte(b);
			end
			6: begin
				do v = 16'($urandom_range(0, 'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
				push_u(high_half());
				push_u(v);
			end
			default: begin
				case ($urandom_range(0, 5))
					0: ;
					1: push_byte(CH_BSLASH);
					2: begin
						push_byte(CH_BSLASH);
						push_byte(CH_LOW_U);
						push_hex_digits(bmp_point(), $urandom_range(0, 3));
					end
					3: push_u(high_half());
					4: begin
						push_u(high_half());
						push_byte(CH_BSLASH);
					end
					default: begin
						push_u(high_half());
						push_byte(CH_BSLASH);
						push_byte(CH_LOW_U);
						push_hex_digits(low_half(), $urandom_range(0, 3));
					end
				endcase
				push_eot();
			end
		endcase
	endtask

	task automatic push_string();
		int         pieces;
		int         r;
		logic [7:0] b;
		pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
		push_byte(CH_QUOTE);
		for (int i = 0; i < pieces; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_fault();
				return;
			end else if (r < 45) begin
				do b = 8'($urandom_range('h20, 'hFF));
				while (b == CH_QUOTE || b == CH_BSLASH);
				push_byte(b);
			end else if (r < 65) begin
				push_byte(CH_BSLASH);
				push_byte(escape_letter($urandom_range(0, 7)));
			end else if (r < 85) begin
				push_u(bmp_point());
			end else begin
				push_u(high_half());
				push_u(low_half());
			end
		end
		push_byte(CH_QUOTE);
	endtask

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		text_word_t w;
		if (arst_n) begin
			if (!text_ch.valid || in_fire) begin
				if (gap_left > 0) begin
					text_ch.valid <= 1'b0;
					gap_left--;
				end else if (text_q.size() == 0) begin
					text_ch.valid <= 1'b0;
				end else if (text_q[0].hold) begin
					text_ch.valid <= 1'b0;
					if (decoded_q.size() == 0) void'(text_q.pop_front());
				end else begin
					w = text_q.pop_front();
					text_ch.valid       <= 1'b1;
					text_ch.text_byte   <= w.chr;
					text_ch.end_of_text <= w.eot;
					gap_left = pick_gap(0);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap(1);
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n) begin
			cycles++;
			in_fire <= text_ch.valid && text_ch.ready;
			if (text_ch.valid && text_ch.ready)
				unescape_step(text_ch.text_byte, text_ch.end_of_text);
			if (res_ch.valid && res_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$error("result word with none expected: out_byte %h kind %0d error_code %0d",
						res_ch.out_byte, res_ch.kind, res_ch.error_code);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (res_ch.out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, res_ch.out_byte);
						mismatches++;
					end
					if (res_ch.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
						mismatches++;
					end
					if (res_ch.error_code !== want.code) begin
						$error("error_code: expected %0d, got %0d", want.code,
							res_ch.error_code);
						mismatches++;
					end
					if (res_ch.last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last,
							res_ch.last_of_run);
						mismatches++;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		bit held;
		int r;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		text_ch.valid       = 1'b0;
		text_ch.text_byte   = 8'h00;
		text_ch.end_of_text = 1'b0;
		res_ch.ready        = 1'b0;
		in_fire             = 1'b0;
		gap_left            = 0;
		stall_left          = 0;
		calm_left[0]        = 0;
		calm_left[1]        = 0;
		mismatches          = 0;
		cycles              = 0;
		words_made          = 0;
		held                = 1'b0;
		clear_state();

		push_byte(8'h00);
		push_byte(8'hFF);
		push_eot();
		push_byte(CH_QUOTE);
		push_byte(CH_SPACE);
		push_byte(8'hFF);
		push_byte(CH_BSLASH);
		push_byte(CH_LOW_T);
		push_u(16'hDBFF);
		push_u(16'hDFFF);
		push_byte(CH_QUOTE);
		push_byte(CH_QUOTE);
		push_byte(8'h1F);
		push_byte(CH_QUOTE);
		push_eot();
		push_hold();

		while (words_made < RUN_ITEMS) begin
			if (!held && words_made > RUN_ITEMS / 2) begin
				push_hold();
				held = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 82) push_string();
			else if (r < 94) push_byte(8'($urandom_range(0, 255)));
			else push_eot();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_q.size() > 0 || text_ch.valid) @(posedge clk);
		while (decoded_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
